### src/nprc_pkg.sv
// Shared types, constants and register codes of the PCM rate and format converter.
`timescale 1ns / 1ps
package nprc_pkg;

  localparam int RATE_W   = 18;
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_UP_DEF  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SAMPLE_W-1:0] SIGN_BIAS   = 16'h8000;
  localparam logic [7:0]          FLT_EXP_OFS = 8'd112;

  localparam logic [RATE_W-1:0] SRC_RATE_RST = 18'd44100;
  localparam logic [RATE_W-1:0] DST_RATE_RST = 18'd48000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_RATE   = 3'd0,
    REG_DST_RATE   = 3'd1,
    REG_SRC_STEREO = 3'd2,
    REG_SRC_WIDE   = 3'd3,
    REG_DST_MODE   = 3'd4,
    REG_DST_STEREO = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_U8  = 2'd0,
    MODE_S16 = 2'd1,
    MODE_F32 = 2'd2
  } dst_mode_t;

  typedef struct packed {
    logic      src_stereo;
    logic      src_wide;
    dst_mode_t dst_mode;
    logic      dst_stereo;
  } fmt_cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

endpackage

### src/nprc_if.sv
// Request and frame channel interfaces of the PCM rate and format converter.
`timescale 1ns / 1ps
interface nprc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          block_start;
  logic [nprc_pkg::SAMPLE_W-1:0] left_raw;
  logic [nprc_pkg::SAMPLE_W-1:0] right_raw;

  modport source(output valid, block_start, left_raw, right_raw, input ready);
  modport sink(input valid, block_start, left_raw, right_raw, output ready);
endinterface

interface nprc_out_if;
  logic                        valid;
  logic                        ready;
  logic [nprc_pkg::WORD_W-1:0] out_left;
  logic [nprc_pkg::WORD_W-1:0] out_right;
  logic                        run_last;

  modport source(output valid, out_left, out_right, run_last, input ready);
  modport sink(input valid, out_left, out_right, run_last, output ready);
endinterface

### src/nprc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nprc_div #(
  parameter int W = nprc_pkg::RATE_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CW'(W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // partial remainder stays below the divisor, so W bits hold it
      rem_nxt  = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt  = {quo_r[W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

### src/nprc_front.sv
// Front end: takes requests, advances the phase and works out the frame count.
`timescale 1ns / 1ps
module nprc_front #(
  parameter int MAX_UP = nprc_pkg::MAX_UP_DEF,
  parameter int CW     = $clog2(MAX_UP + 1),
  parameter int EW     = 2 * nprc_pkg::SAMPLE_W + CW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nprc_in_if.sink                     in_ch,
  input  nprc_pkg::fmt_cfg_t          fmt,
  input  logic [nprc_pkg::RATE_W-1:0] src_rate,
  input  logic [nprc_pkg::RATE_W-1:0] dst_rate,
  output logic                        push_valid,
  input  logic                        push_ready,
  output logic [EW-1:0]               push_data
);

  localparam int RW = nprc_pkg::RATE_W;
  localparam int SW = nprc_pkg::SAMPLE_W;

  nprc_pkg::front_state_t state_r, state_nxt;
  logic [RW-1:0] phase_r, phase_nxt;   // always below src_rate after a mapped frame
  logic [SW-1:0] lb_r, rb_r;
  logic [SW-1:0] lb_in, rb_in;
  logic [RW-1:0] acc0;
  logic          accept;
  logic          div_start;
  logic [RW-1:0] dividend;
  logic          div_done;
  logic [RW-1:0] div_quo;
  logic [RW-1:0] div_rem;
  logic [CW-1:0] frame_cnt;

  function automatic logic [SW-1:0] widen(input logic [SW-1:0] raw, input logic wide);
    return wide ? (raw ^ nprc_pkg::SIGN_BIAS) : {raw[7:0], 8'h00};
  endfunction

  assign accept    = in_ch.valid && in_ch.ready;
  assign acc0      = in_ch.block_start ? '0 : phase_r;
  assign div_start = accept && (acc0 < dst_rate);
  // count = floor((dst - acc - 1) / src) + 1, new phase = src - 1 - remainder
  assign dividend  = dst_rate - acc0 - RW'(1);

  assign lb_in = widen(in_ch.left_raw, fmt.src_wide);
  assign rb_in = fmt.src_stereo ? widen(in_ch.right_raw, fmt.src_wide) : lb_in;

  nprc_div #(.W(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (src_rate),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign frame_cnt = (div_quo >= RW'(MAX_UP)) ? CW'(MAX_UP) : (CW'(div_quo) + CW'(1));
  assign push_data = {lb_r, rb_r, frame_cnt};

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    unique case (state_r)
      nprc_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        // ready is high in this state, so valid alone marks an accept
        if (in_ch.valid) begin
          if (acc0 < dst_rate) begin
            state_nxt = nprc_pkg::F_DIV;
          end else begin
            phase_nxt = acc0 - dst_rate;
          end
        end
      end
      nprc_pkg::F_DIV: begin
        if (div_done) begin
          phase_nxt = src_rate - RW'(1) - div_rem;
          state_nxt = nprc_pkg::F_PUSH;
        end
      end
      nprc_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = nprc_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = nprc_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nprc_pkg::F_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      lb_r <= lb_in;
      rb_r <= rb_in;
    end
  end

endmodule

### src/nprc_fifo.sv
// Short request queue between front and back end.
`timescale 1ns / 1ps
module nprc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nprc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != NW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

### src/nprc_back.sv
// Back end: encodes a queued frame and repeats it once per output cycle unless the receiver stalls.
`timescale 1ns / 1ps
module nprc_back #(
  parameter int MAX_UP = nprc_pkg::MAX_UP_DEF,
  parameter int CW     = $clog2(MAX_UP + 1),
  parameter int EW     = 2 * nprc_pkg::SAMPLE_W + CW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nprc_pkg::fmt_cfg_t fmt,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [EW-1:0]      pop_data,
  nprc_out_if.source         out_ch
);

  localparam int SW = nprc_pkg::SAMPLE_W;
  localparam int WW = nprc_pkg::WORD_W;

  logic [CW-1:0] rem_r, rem_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WW-1:0] lw_r, rw_r;
  logic [WW-1:0] out_left_r, out_right_r;
  logic          out_last_r;
  logic [SW-1:0] ent_lb, ent_rb;
  logic [CW-1:0] ent_cnt;
  logic [WW-1:0] enc_l, enc_r;
  logic          load;
  logic          pop;

  function automatic logic [WW-1:0] to_float(input logic [SW-1:0] b);
    logic [SW-1:0] mag;
    logic [3:0]    p;
    logic [23:0]   shifted;
    logic [7:0]    ex;
    mag = b[SW-1] ? (b - nprc_pkg::SIGN_BIAS) : (nprc_pkg::SIGN_BIAS - b);
    p = '0;
    for (int i = 0; i < SW; i++) begin
      if (mag[i]) begin
        p = 4'(i);
      end
    end
    ex      = nprc_pkg::FLT_EXP_OFS + {4'b0, p};
    shifted = {8'b0, mag} << (5'd23 - {1'b0, p});
    if (mag == '0) begin
      return '0;
    end
    return {~b[SW-1], ex, shifted[22:0]};
  endfunction

  function automatic logic [WW-1:0] encode(input logic [SW-1:0] b,
                                           input nprc_pkg::dst_mode_t m);
    logic [WW-1:0] w;
    unique case (m)
      nprc_pkg::MODE_U8:  w = {24'b0, b[SW-1:8]};
      nprc_pkg::MODE_S16: w = {16'b0, b ^ nprc_pkg::SIGN_BIAS};
      nprc_pkg::MODE_F32: w = to_float(b);
      default:            w = '0;
    endcase
    return w;
  endfunction

  assign {ent_lb, ent_rb, ent_cnt} = pop_data;
  assign enc_l = encode(ent_lb, fmt.dst_mode);
  assign enc_r = fmt.dst_stereo ? encode(ent_rb, fmt.dst_mode) : '0;

  assign load      = (rem_r != '0) && (!out_valid_r || out_ch.ready);
  // refill the hold stage as its last frame moves to the output register
  assign pop_ready = (rem_r == '0) || ((rem_r == CW'(1)) && load);
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      rem_nxt       = rem_r - CW'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      rem_nxt = ent_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lw_r <= enc_l;
      rw_r <= enc_r;
    end
    if (load) begin
      out_left_r  <= lw_r;
      out_right_r <= rw_r;
      out_last_r  <= (rem_r == CW'(1));
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_left_r;
  assign out_ch.out_right = out_right_r;
  assign out_ch.run_last  = out_last_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= CW'(MAX_UP))
    else $error("frame repeat count above limit");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (rem_r == CW'(1))) |=> (out_ch.valid && out_ch.run_last))
    else $error("final frame of a request not marked last");

  a_no_pop_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (rem_r != '0)) |=> $past(load))
    else $error("queue popped while frames remain");
`endif

endmodule

### src/nearest_pcm_rate_format_converter.sv
// Top level: configuration registers and front end, queue and back end.
// A request that maps to frames holds the front end through accept, 18 divider steps
// (one quotient bit per cycle), the done strobe and the queue push; one that maps to none
// is taken every cycle. The back end sends one frame per cycle unless the receiver
// stalls, up to MAX_UP per request, each through the hold stage and output register.
// Synchronous active-low reset restores the register defaults, clears the phase and
// empties the queue and output stage.
`timescale 1ns / 1ps
module nearest_pcm_rate_format_converter #(
  parameter int MAX_UP      = nprc_pkg::MAX_UP_DEF,
  parameter int QUEUE_DEPTH = nprc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nprc_in_if.sink                        in_ch,
  nprc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [nprc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [nprc_pkg::RATE_W-1:0]    cfg_data
);

  localparam int RW = nprc_pkg::RATE_W;
  localparam int CW = $clog2(MAX_UP + 1);
  localparam int EW = 2 * nprc_pkg::SAMPLE_W + CW;

  logic [RW-1:0]      src_rate_r, src_rate_nxt;
  logic [RW-1:0]      dst_rate_r, dst_rate_nxt;
  nprc_pkg::fmt_cfg_t fmt_r, fmt_nxt;
  logic [RW-1:0]      src_rate_eff, dst_rate_eff;

  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  always_comb begin
    src_rate_nxt = src_rate_r;
    dst_rate_nxt = dst_rate_r;
    fmt_nxt      = fmt_r;
    if (cfg_we) begin
      unique case (nprc_pkg::cfg_reg_t'(cfg_idx))
        nprc_pkg::REG_SRC_RATE:   src_rate_nxt       = cfg_data;
        nprc_pkg::REG_DST_RATE:   dst_rate_nxt       = cfg_data;
        nprc_pkg::REG_SRC_STEREO: fmt_nxt.src_stereo = cfg_data[0];
        nprc_pkg::REG_SRC_WIDE:   fmt_nxt.src_wide   = cfg_data[0];
        nprc_pkg::REG_DST_MODE:   fmt_nxt.dst_mode   = nprc_pkg::dst_mode_t'(cfg_data[1:0]);
        nprc_pkg::REG_DST_STEREO: fmt_nxt.dst_stereo = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rate_r       <= nprc_pkg::SRC_RATE_RST;
      dst_rate_r       <= nprc_pkg::DST_RATE_RST;
      fmt_r.src_stereo <= 1'b1;
      fmt_r.src_wide   <= 1'b1;
      fmt_r.dst_mode   <= nprc_pkg::MODE_F32;
      fmt_r.dst_stereo <= 1'b1;
    end else begin
      src_rate_r <= src_rate_nxt;
      dst_rate_r <= dst_rate_nxt;
      fmt_r      <= fmt_nxt;
    end
  end

  // a zero rate behaves as one
  assign src_rate_eff = (src_rate_r == '0) ? RW'(1) : src_rate_r;
  assign dst_rate_eff = (dst_rate_r == '0) ? RW'(1) : dst_rate_r;

  nprc_front #(.MAX_UP(MAX_UP), .CW(CW), .EW(EW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fmt        (fmt_r),
    .src_rate   (src_rate_eff),
    .dst_rate   (dst_rate_eff),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nprc_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nprc_back #(.MAX_UP(MAX_UP), .CW(CW), .EW(EW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

### sim/tb.sv
// Self-checking testbench for the nearest-neighbor PCM rate and format converter.
`timescale 1ns / 1ps
module tb;

  localparam int MAX_FRAMES        = nprc_pkg::MAX_UP_DEF;
  localparam int RANDOM_ITEMS      = 288;
  localparam int RANDOM_MIN_FRAMES = 48;
  localparam int PHASE_ITEMS       = 36;
  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 30;
  localparam int CYCLE_LIMIT       = 500000;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  typedef struct packed {
    logic [nprc_pkg::WORD_W-1:0] left;
    logic [nprc_pkg::WORD_W-1:0] right;
    logic                        last;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [nprc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [nprc_pkg::RATE_W-1:0]    cfg_data;

  nprc_in_if  in_if();
  nprc_out_if out_if();

  nearest_pcm_rate_format_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and phase
  logic [nprc_pkg::RATE_W-1:0] src_rate_set   = nprc_pkg::SRC_RATE_RST;
  logic [nprc_pkg::RATE_W-1:0] dst_rate_set   = nprc_pkg::DST_RATE_RST;
  logic                        src_stereo_set = 1'b1;
  logic                        src_wide_set   = 1'b1;
  logic [1:0]                  out_mode_set   = nprc_pkg::MODE_F32;
  logic                        dst_stereo_set = 1'b1;
  logic [20:0]                 phase_model    = '0;

  frame_t frames_due[$];

  int  err_count        = 0;
  int  requests_sent    = 0;
  int  frames_predicted = 0;
  int  frames_checked   = 0;
  int  reqs_silent      = 0;
  int  reqs_capped      = 0;
  int  settings_count   = 0;
  int  cycle_count      = 0;
  bit  idle_on          = 1'b1;
  int  hold_epoch       = 0;
  int  hold_ack         = 0;
  int  hold_left        = 0;
  int  stall_left       = 0;
  int  audio_rates[6]   = '{8000, 11025, 22050, 44100, 48000, 96000};

  function automatic logic [15:0] widen(input logic [15:0] raw);
    return src_wide_set ? (raw ^ nprc_pkg::SIGN_BIAS) : {raw[7:0], 8'h00};
  endfunction

  // biased sample -> IEEE single of (b - 32768) / 32768
  function automatic logic [31:0] float_word(input logic [15:0] b);
    logic        sgn;
    logic [15:0] mag;
    logic [39:0] shifted;
    int          msb;
    if (b == nprc_pkg::SIGN_BIAS) return '0;
    sgn = (b < nprc_pkg::SIGN_BIAS);
    mag = sgn ? (nprc_pkg::SIGN_BIAS - b) : (b - nprc_pkg::SIGN_BIAS);
    msb = 0;
    for (int i = 0; i < 16; i++) if (mag[i]) msb = i;
    shifted = 40'(mag) << (23 - msb);
    return {sgn, 8'(nprc_pkg::FLT_EXP_OFS + msb), shifted[22:0]};
  endfunction

  function automatic logic [31:0] encode_word(input logic [15:0] b);
    case (out_mode_set)
      nprc_pkg::MODE_U8:  return {24'h0, b[15:8]};
      nprc_pkg::MODE_S16: return {16'h0, b ^ nprc_pkg::SIGN_BIAS};
      nprc_pkg::MODE_F32: return float_word(b);
      default:            return '0;
    endcase
  endfunction

  // advance the phase for one request and queue the frames it maps to
  function automatic int map_request(input logic bs, input logic [15:0] l_raw, r_raw);
    logic [63:0] sr, dr, acc, due;
    logic [15:0] lb, rb;
    frame_t      f;
    int          n;
    sr = (src_rate_set == 0) ? 64'd1 : 64'(src_rate_set);
    dr = (dst_rate_set == 0) ? 64'd1 : 64'(dst_rate_set);
    if (bs) phase_model = '0;
    acc = 64'(phase_model);
    if (acc < dr) begin
      due = (dr - acc + sr - 1) / sr;
      acc = acc + due * sr - dr;
    end else begin
      due = 0;
      acc = acc - dr;
    end
    phase_model = acc[20:0];
    lb = widen(l_raw);
    rb = src_stereo_set ? widen(r_raw) : lb;
    f.left  = encode_word(lb);
    f.right = dst_stereo_set ? encode_word(rb) : '0;
    n = (due > MAX_FRAMES) ? MAX_FRAMES : int'(due);
    for (int k = 0; k < n; k++) begin
      f.last = (k == n - 1);
      frames_due.push_back(f);
    end
    if (n == 0) reqs_silent++;
    if (due > MAX_FRAMES) reqs_capped++;
    return n;
  endfunction

  function automatic void log_mismatch(input string why, input frame_t want, got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s: expected L=%h R=%h last=%b, got L=%h R=%h last=%b", $time, why,
               want.left, want.right, want.last, got.left, got.right, got.last);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_epoch != hold_ack) begin
      hold_ack     <= hold_epoch;
      hold_left    <= HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 15) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.left  = out_if.out_left;
      got.right = out_if.out_right;
      got.last  = out_if.run_last;
      if (frames_due.size() == 0) begin
        log_mismatch("unexpected frame", '0, got);
      end else begin
        want = frames_due.pop_front();
        if (got != want) log_mismatch("frame mismatch", want, got);
      end
      frames_checked++;
    end
  end

  task automatic cfg_put(input nprc_pkg::cfg_reg_t idx,
                         input logic [nprc_pkg::RATE_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      nprc_pkg::REG_SRC_RATE:   src_rate_set   = data;
      nprc_pkg::REG_DST_RATE:   dst_rate_set   = data;
      nprc_pkg::REG_SRC_STEREO: src_stereo_set = data[0];
      nprc_pkg::REG_SRC_WIDE:   src_wide_set   = data[0];
      nprc_pkg::REG_DST_MODE:   out_mode_set   = data[1:0];
      nprc_pkg::REG_DST_STEREO: dst_stereo_set = data[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [nprc_pkg::RATE_W-1:0] sr, dr, ss, sw, dm, ds);
    cfg_put(nprc_pkg::REG_SRC_RATE, sr);
    cfg_put(nprc_pkg::REG_DST_RATE, dr);
    cfg_put(nprc_pkg::REG_SRC_STEREO, ss);
    cfg_put(nprc_pkg::REG_SRC_WIDE, sw);
    cfg_put(nprc_pkg::REG_DST_MODE, dm);
    cfg_put(nprc_pkg::REG_DST_STEREO, ds);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // valid stays up across back-to-back requests; only lowered for a gap or at drain
  task automatic send_request(input logic bs, input logic [15:0] l_raw, r_raw);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.block_start <= bs;
    in_if.left_raw    <= l_raw;
    in_if.right_raw   <= r_raw;
    do @(posedge clk); while (!in_if.ready);
    frames_predicted += map_request(bs, l_raw, r_raw);
    requests_sent++;
  endtask

  // must be called in the step of the last acceptance
  task automatic drain_frames();
    in_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    // requests mapping to no frame may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_stream(input int count);
    int   run_left;
    logic bs;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      bs = (run_left == 0) || ($urandom_range(0, 24) == 0);
      if (bs) run_left = $urandom_range(4, 40);
      run_left--;
      send_request(bs, pick_sample(), pick_sample());
    end
    drain_frames();
  endtask

  task automatic random_settings();
    int base, sr, dr;
    base = $urandom_range(2000, 262143);
    case ($urandom_range(0, 3))
      0: begin
        dr = base;
        sr = base / $urandom_range(1, 10);
      end
      1: begin
        sr = base;
        dr = base / $urandom_range(1, 3);
      end
      2: begin
        sr = base;
        dr = $urandom_range(base / 2, (base > 131071) ? 262143 : base * 2);
      end
      default: begin
        sr = audio_rates[$urandom_range(0, 5)];
        dr = audio_rates[$urandom_range(0, 5)];
      end
    endcase
    // junk in the unused upper bits of the narrow registers
    program_regs(18'(sr), 18'(dr),
                 18'($urandom_range(0, 1)) | (18'($urandom) & 18'h3FFFE),
                 18'($urandom_range(0, 1)) | (18'($urandom) & 18'h3FFFE),
                 18'($urandom_range(0, 3)) | (18'($urandom) & 18'h3FFFC),
                 18'($urandom_range(0, 1)) | (18'($urandom) & 18'h3FFFE));
  endtask

  // register defaults straight out of reset: 44.1k -> 48k, stereo 16-bit in, float out
  task automatic test_reset_values();
    send_request(1'b1, 16'h0000, 16'hFFFF);
    send_request(1'b0, 16'h7FFF, 16'h8000);
    send_request(1'b0, 16'h8000, 16'h0001);
    send_request(1'b0, 16'hFFFF, 16'h7FFF);
    send_request(1'b0, 16'h0001, 16'h4000);
    send_request(1'b0, 16'hC000, 16'h0100);
    drain_frames();
  endtask

  task automatic test_formats();
    // mono 8-bit in, u8 out; high byte of an 8-bit sample must be ignored
    program_regs(18'd48000, 18'd48000, 18'd0, 18'd0, 18'(nprc_pkg::MODE_U8), 18'd1);
    send_request(1'b1, 16'hAB80, 16'h1234);
    send_request(1'b0, 16'h00FF, 16'h0000);
    send_request(1'b0, 16'hFF00, 16'hFFFF);
    drain_frames();
    // stereo 8-bit in, s16 out, mono destination
    program_regs(18'd48000, 18'd48000, 18'd1, 18'd0, 18'(nprc_pkg::MODE_S16), 18'd0);
    send_request(1'b1, 16'h0000, 16'h00FF);
    send_request(1'b0, 16'h1280, 16'h7F7F);
    send_request(1'b0, 16'h00FF, 16'hFF01);
    drain_frames();
    // undefined output mode gives zero words
    program_regs(18'd48000, 18'd48000, 18'd1, 18'd1, 18'(MODE_UNDEF), 18'd1);
    send_request(1'b1, 16'h1234, 16'h8765);
    send_request(1'b0, 16'hFFFF, 16'h0000);
    drain_frames();
    program_regs(18'd48000, 18'd48000, 18'd0, 18'd1, 18'(nprc_pkg::MODE_F32), 18'd1);
    send_request(1'b1, 16'h8000, 16'h7FFF);
    send_request(1'b0, 16'h0003, 16'hFFFF);
    drain_frames();
  endtask

  task automatic test_rate_extremes();
    // maximum up-ratio: frame count saturates
    program_regs(18'd1, 18'h3FFFF, 18'd1, 18'd1, 18'(nprc_pkg::MODE_S16), 18'd1);
    send_request(1'b1, 16'h1111, 16'h2222);
    send_request(1'b0, 16'hEEEE, 16'hDDDD);
    drain_frames();
    // zero rates behave as one
    program_regs(18'd0, 18'd0, 18'd1, 18'd1, 18'(nprc_pkg::MODE_S16), 18'd1);
    send_request(1'b1, 16'h0F0F, 16'hF0F0);
    send_request(1'b0, 16'h5555, 16'hAAAA);
    drain_frames();
    // maximum down-ratio: only block starts yield a frame
    program_regs(18'h3FFFF, 18'd1, 18'd1, 18'd1, 18'(nprc_pkg::MODE_U8), 18'd1);
    send_request(1'b1, 16'h4000, 16'hC000);
    send_request(1'b0, 16'h0000, 16'hFFFF);
    send_request(1'b0, 16'hFFFF, 16'h0000);
    send_request(1'b1, 16'h8001, 16'h7FFE);
    drain_frames();
  endtask

  task automatic test_random_streams();
    int first_req, first_frame;
    first_req   = requests_sent;
    first_frame = frames_predicted;
    while (requests_sent - first_req < RANDOM_ITEMS ||
           frames_predicted - first_frame < RANDOM_MIN_FRAMES) begin
      random_settings();
      send_stream(PHASE_ITEMS);
    end
  endtask

  // receiver holds off while requests keep coming, so the queue fills and input stalls
  task automatic test_output_backpressure();
    idle_on <= 1'b0;
    program_regs(18'd16000, 18'd48000, 18'd1, 18'd1, 18'(nprc_pkg::MODE_S16), 18'd1);
    hold_epoch <= hold_epoch + 1;
    send_stream(16);
  endtask

  task automatic test_streaming();
    random_settings();
    send_stream(40);
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= nprc_pkg::REG_SRC_RATE;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.block_start <= 1'b0;
    in_if.left_raw    <= '0;
    in_if.right_raw   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_formats();
    test_rate_extremes();
    test_random_streams();
    test_output_backpressure();
    test_streaming();

    $display("Ran %0d requests over %0d register settings, %0d frames checked",
             requests_sent, settings_count, frames_checked);
    $display("%0d requests mapped to no frame, %0d hit the up-ratio cap",
             reqs_silent, reqs_capped);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
